FILE: hdl/mp2s_pkg.sv
// Shared types, constants and helpers for the 2x2 max pooling stream block.
// No dependencies; every other file of the block refers to this package.
`timescale 1ns / 1ps

package mp2s_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int PIX_W         = 16;
  localparam int VAL_W         = 15;
  localparam int ROW_W         = 10;
  localparam int DIM_W         = 11;
  localparam int STRIDE_W      = 3;
  localparam int MAX_HEIGHT    = 1024;
  localparam int STRIDE_MAX    = 4;
  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_POOL_STRIDE  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [DIM_W-1:0]    frame_width;
    logic [DIM_W-1:0]    frame_height;
    logic [STRIDE_W-1:0] pool_stride;
  } cfg_t;

  // Window slots in output order: up-left, up-right, bottom-left, bottom-right.
  typedef struct packed {
    logic [3:0]              mask;
    logic [3:0][VAL_W-1:0]   val;
    logic [ROW_W-1:0]        up_row;
    logic [ROW_W-1:0]        bot_row;
    logic [ROW_W-1:0]        left_col;
    logic [ROW_W-1:0]        right_col;
    logic                    fe_up;
    logic                    fe_left;
  } entry_t;

  function automatic logic [VAL_W-1:0] pool_max(input logic [VAL_W-1:0] a,
                                                input logic signed [PIX_W-1:0] b);
    logic [VAL_W-1:0] res;
    res = a;
    if (!b[PIX_W-1] && (b[VAL_W-1:0] > a)) begin
      res = b[VAL_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: hdl/mp2s_if.sv
// Stream channel interfaces: pixel input and pooled result output.
// Depends on mp2s_pkg for field widths.
`timescale 1ns / 1ps

interface mp2s_pix_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mp2s_pkg::PIX_W-1:0]     pixel_value;

  modport source (output valid, output pixel_value, input ready);
  modport sink   (input valid, input pixel_value, output ready);
endinterface

interface mp2s_res_if;
  logic                          valid;
  logic                          ready;
  logic [mp2s_pkg::VAL_W-1:0]    pooled_value;
  logic [mp2s_pkg::ROW_W-1:0]    out_row;
  logic [mp2s_pkg::ROW_W-1:0]    out_col;
  logic                          run_last;
  logic                          frame_end;

  modport source (output valid, output pooled_value, output out_row, output out_col,
                  output run_last, output frame_end, input ready);
  modport sink   (input valid, input pooled_value, input out_row, input out_col,
                  input run_last, input frame_end, output ready);
endinterface

FILE: hdl/max_pool_2x2_stream.sv
// Streaming 2x2 max pooling with configurable stride: one pixel per cycle in,
// one pooled result per cycle out while results are taken. Pixels are taken at
// one per clock as long as the four-entry queue between front and back ends has
// room; the front end does one line store read and one write per pixel. A pixel
// closing k windows (k up to four at stride one) gives k results, sent one at a
// time, so sustained input rate is one pixel per cycle whenever results average
// at most one per pixel. Results pass the stage-one, queue and output registers.
// No clearing pass: unwritten line store entries feed only masked-off windows.
// Depends on mp2s_pkg, mp2s_if, mp2s_cfg, mp2s_front, mp2s_fifo, mp2s_back.
`timescale 1ns / 1ps

module max_pool_2x2_stream #(
  parameter int MAX_WIDTH = mp2s_pkg::MAX_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mp2s_pkg::ADDR_W-1:0]   paddr,
  input  logic [mp2s_pkg::DATA_W-1:0]   pwdata,
  output logic [mp2s_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  mp2s_pix_if.sink                      pix_i,
  mp2s_res_if.source                    res_o
);

  mp2s_pkg::cfg_t   cfg;
  logic             restart;
  logic             push, full, pop, empty;
  mp2s_pkg::entry_t entry, head;

  mp2s_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg_o     (cfg),
    .restart_o (restart)
  );

  mp2s_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .restart_i (restart),
    .pix       (pix_i),
    .push_o    (push),
    .entry_o   (entry),
    .full_i    (full)
  );

  mp2s_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  mp2s_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .res     (res_o)
  );

endmodule

FILE: hdl/mp2s_cfg.sv
// APB-style register file: frame width, frame height, pool stride.
// Depends on mp2s_pkg; any write pulses restart_o to restart the frame.
`timescale 1ns / 1ps

module mp2s_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mp2s_pkg::ADDR_W-1:0]   paddr,
  input  logic [mp2s_pkg::DATA_W-1:0]   pwdata,
  output logic [mp2s_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output mp2s_pkg::cfg_t                cfg_o,
  output logic                          restart_o
);

  mp2s_pkg::cfg_t   cfg_q;
  mp2s_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx       = mp2s_pkg::reg_idx_e'(paddr[3:2]);
  assign wr_en     = psel & penable & pwrite;
  assign pready    = 1'b1;
  assign restart_o = wr_en;
  assign cfg_o     = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= mp2s_pkg::DIM_W'(32);
      cfg_q.frame_height <= mp2s_pkg::DIM_W'(32);
      cfg_q.pool_stride  <= mp2s_pkg::STRIDE_W'(2);
    end else if (wr_en) begin
      case (idx)
        mp2s_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= pwdata[mp2s_pkg::DIM_W-1:0];
        mp2s_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= pwdata[mp2s_pkg::DIM_W-1:0];
        mp2s_pkg::REG_POOL_STRIDE:  cfg_q.pool_stride  <= pwdata[mp2s_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      mp2s_pkg::REG_FRAME_WIDTH:  prdata = mp2s_pkg::DATA_W'(cfg_q.frame_width);
      mp2s_pkg::REG_FRAME_HEIGHT: prdata = mp2s_pkg::DATA_W'(cfg_q.frame_height);
      mp2s_pkg::REG_POOL_STRIDE:  prdata = mp2s_pkg::DATA_W'(cfg_q.pool_stride);
      default:                    prdata = '0;
    endcase
  end

endmodule

FILE: hdl/mp2s_front.sv
// Front end: pixel intake, position counters, line store and window maxima.
// Depends on mp2s_pkg and mp2s_if; pushes one entry per window-closing pixel.
`timescale 1ns / 1ps

module mp2s_front #(
  parameter int MAX_WIDTH = mp2s_pkg::MAX_WIDTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mp2s_pkg::cfg_t  cfg_i,
  input  logic            restart_i,
  mp2s_pix_if.sink        pix,
  output logic            push_o,
  output mp2s_pkg::entry_t entry_o,
  input  logic            full_i
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int SW = ((CW > mp2s_pkg::STRIDE_W) ? CW : mp2s_pkg::STRIDE_W) + 1;
  localparam int RW = mp2s_pkg::ROW_W;
  localparam int HW = mp2s_pkg::DIM_W;
  localparam int PW = mp2s_pkg::PIX_W;

  typedef struct packed {
    logic signed [PW-1:0] cur;
    logic signed [PW-1:0] pp;
    logic                 up;
    logic                 bot;
    logic                 lc;
    logic                 rc;
    logic                 fe_up;
    logic                 fe_left;
    logic [RW-1:0]        up_row;
    logic [RW-1:0]        bot_row;
    logic [RW-1:0]        left_col;
    logic [RW-1:0]        right_col;
    logic                 row_end;
  } stage_t;

  logic [mp2s_pkg::STRIDE_W-1:0] s_eff;
  logic [RW-1:0]                 h_m1;
  logic [CW-1:0]                 w_m1;
  logic                          s_one;

  logic [RW-1:0]        row_q;
  logic [CW-1:0]        col_q;
  logic [1:0]           rph_q, cph_q;
  logic [RW-1:0]        rquo_q;
  logic [CW-1:0]        cquo_q;
  logic signed [PW-1:0] pp_q;
  logic signed [PW-1:0] pa_q;
  logic signed [PW-1:0] rd_q;
  logic signed [PW-1:0] line_mem_q [MAX_WIDTH];

  logic                 s1_v_q;
  stage_t               s1_q, s1_d;

  logic                 accept, s1_adv, row_end, rph_wrap, cph_wrap;
  logic [3:0]           mask;
  logic [mp2s_pkg::VAL_W-1:0] m0, m_l, m_u, m_ul;

  always_comb begin
    if (cfg_i.pool_stride == '0) begin
      s_eff = mp2s_pkg::STRIDE_W'(1);
    end else if (cfg_i.pool_stride > mp2s_pkg::STRIDE_W'(mp2s_pkg::STRIDE_MAX)) begin
      s_eff = mp2s_pkg::STRIDE_W'(mp2s_pkg::STRIDE_MAX);
    end else begin
      s_eff = cfg_i.pool_stride;
    end
    if (cfg_i.frame_height == '0) begin
      h_m1 = '0;
    end else if (cfg_i.frame_height > HW'(mp2s_pkg::MAX_HEIGHT)) begin
      h_m1 = RW'(mp2s_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = RW'(cfg_i.frame_height - HW'(1));
    end
    if (cfg_i.frame_width == '0) begin
      w_m1 = '0;
    end else if (32'(cfg_i.frame_width) > 32'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(cfg_i.frame_width - HW'(1));
    end
  end

  assign s_one    = (s_eff == mp2s_pkg::STRIDE_W'(1));
  assign row_end  = (col_q == w_m1);
  assign rph_wrap = ({1'b0, rph_q} == s_eff - mp2s_pkg::STRIDE_W'(1));
  assign cph_wrap = ({1'b0, cph_q} == s_eff - mp2s_pkg::STRIDE_W'(1));
  assign accept   = pix.valid & pix.ready;

  // Classify the incoming pixel by the windows it closes.
  always_comb begin
    s1_d.cur       = pix.pixel_value;
    s1_d.pp        = pp_q;
    s1_d.up        = (row_q != '0) && (s_one || (rph_q == 2'd1));
    s1_d.bot       = (row_q == h_m1) && (rph_q == 2'd0);
    s1_d.lc        = (col_q != '0) && (s_one || (cph_q == 2'd1));
    s1_d.rc        = row_end && (cph_q == 2'd0);
    s1_d.fe_up     = (HW'(row_q) + HW'(s_eff)) > (HW'(h_m1) + HW'(1));
    s1_d.fe_left   = (SW'(col_q) + SW'(s_eff)) > (SW'(w_m1) + SW'(1));
    s1_d.up_row    = s_one ? (rquo_q - RW'(1)) : rquo_q;
    s1_d.bot_row   = rquo_q;
    s1_d.left_col  = RW'(s_one ? (cquo_q - CW'(1)) : cquo_q);
    s1_d.right_col = RW'(cquo_q);
    s1_d.row_end   = row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
      rquo_q <= '0;
      cquo_q <= '0;
      pp_q   <= '0;
    end else if (restart_i) begin
      row_q  <= '0;
      col_q  <= '0;
      rph_q  <= '0;
      cph_q  <= '0;
      rquo_q <= '0;
      cquo_q <= '0;
      pp_q   <= '0;
    end else if (accept) begin
      if (row_end) begin
        col_q  <= '0;
        cph_q  <= '0;
        cquo_q <= '0;
        pp_q   <= '0;
        if (row_q == h_m1) begin
          row_q  <= '0;
          rph_q  <= '0;
          rquo_q <= '0;
        end else begin
          row_q  <= row_q + RW'(1);
          rph_q  <= rph_wrap ? 2'd0 : rph_q + 2'd1;
          rquo_q <= rph_wrap ? rquo_q + RW'(1) : rquo_q;
        end
      end else begin
        col_q  <= col_q + CW'(1);
        cph_q  <= cph_wrap ? 2'd0 : cph_q + 2'd1;
        cquo_q <= cph_wrap ? cquo_q + CW'(1) : cquo_q;
        pp_q   <= pix.pixel_value;
      end
    end
  end

  // Line store: read-before-write at the pixel's column.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q              <= line_mem_q[col_q];
      line_mem_q[col_q] <= pix.pixel_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  always_comb begin
    m0   = mp2s_pkg::pool_max('0, s1_q.cur);
    m_l  = mp2s_pkg::pool_max(m0, s1_q.pp);
    m_u  = mp2s_pkg::pool_max(m0, rd_q);
    m_ul = mp2s_pkg::pool_max(mp2s_pkg::pool_max(m_u, s1_q.pp), pa_q);
    mask = {s1_q.bot & s1_q.rc, s1_q.bot & s1_q.lc, s1_q.up & s1_q.rc, s1_q.up & s1_q.lc};

    entry_o.mask      = mask;
    entry_o.val[0]    = m_ul;
    entry_o.val[1]    = m_u;
    entry_o.val[2]    = m_l;
    entry_o.val[3]    = m0;
    entry_o.up_row    = s1_q.up_row;
    entry_o.bot_row   = s1_q.bot_row;
    entry_o.left_col  = s1_q.left_col;
    entry_o.right_col = s1_q.right_col;
    entry_o.fe_up     = s1_q.fe_up;
    entry_o.fe_left   = s1_q.fe_left;
  end

  assign s1_adv    = s1_v_q && ((mask == '0) || !full_i);
  assign push_o    = s1_v_q && (mask != '0) && !full_i;
  assign pix.ready = !s1_v_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      pa_q   <= '0;
    end else begin
      if (accept) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (restart_i) begin
        pa_q <= '0;
      end else if (s1_adv) begin
        pa_q <= s1_q.row_end ? '0 : rd_q;
      end
    end
  end

endmodule

FILE: hdl/mp2s_fifo.sv
// Short entry queue between front and back ends.
// Depends on mp2s_pkg for the entry type and depth.
`timescale 1ns / 1ps

module mp2s_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mp2s_pkg::entry_t entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output mp2s_pkg::entry_t head_o,
  output logic             empty_o
);

  localparam int PW = mp2s_pkg::FIFO_PTR_W;

  mp2s_pkg::entry_t slot_q [mp2s_pkg::FIFO_DEPTH];
  logic [PW-1:0]    wr_q, rd_q;
  logic [PW:0]      cnt_q;

  assign full_o  = (cnt_q == (PW+1)'(mp2s_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (PW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (PW+1)'(1);
      end
    end
  end

endmodule

FILE: hdl/mp2s_back.sv
// Back end: turns each queued entry into its pooled results, one per ready cycle.
// Depends on mp2s_pkg and mp2s_if; output register decouples the result channel.
`timescale 1ns / 1ps

module mp2s_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  mp2s_pkg::entry_t head_i,
  output logic             pop_o,
  mp2s_res_if.source       res
);

  logic [3:0] done_q;
  logic [3:0] rem, sel, rest;
  logic [1:0] idx;
  logic       load, last;
  logic       out_v_q;

  logic [mp2s_pkg::VAL_W-1:0] val_d;
  logic [mp2s_pkg::ROW_W-1:0] row_d, col_d;
  logic                       fe_d;

  always_comb begin
    rem = head_i.mask & ~done_q;
    if (rem[0]) begin
      idx = 2'd0;
    end else if (rem[1]) begin
      idx = 2'd1;
    end else if (rem[2]) begin
      idx = 2'd2;
    end else begin
      idx = 2'd3;
    end
    sel  = 4'b0001 << idx;
    rest = rem & ~sel;
    last = (rest == '0);

    val_d = head_i.val[idx];
    case (idx)
      2'd0: begin
        row_d = head_i.up_row;
        col_d = head_i.left_col;
        fe_d  = head_i.fe_up & head_i.fe_left;
      end
      2'd1: begin
        row_d = head_i.up_row;
        col_d = head_i.right_col;
        fe_d  = head_i.fe_up;
      end
      2'd2: begin
        row_d = head_i.bot_row;
        col_d = head_i.left_col;
        fe_d  = head_i.fe_left;
      end
      default: begin
        row_d = head_i.bot_row;
        col_d = head_i.right_col;
        fe_d  = 1'b1;
      end
    endcase
  end

  assign load      = !empty_i && (!out_v_q || res.ready);
  assign pop_o     = load && last;
  assign res.valid = out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      done_q  <= '0;
    end else begin
      if (load) begin
        out_v_q <= 1'b1;
        done_q  <= last ? '0 : (done_q | sel);
      end else if (res.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res.pooled_value <= val_d;
      res.out_row      <= row_d;
      res.out_col      <= col_d;
      res.run_last     <= last;
      res.frame_end    <= fe_d;
    end
  end

endmodule
